FILE: rtl/grs_pkg.sv
// Package for the enhanced-GRE receive sequencer.
// Holds field widths, header constants, status codes and the word types
// passed between front end, queue and back end. No dependencies.
package grs_pkg;

    localparam int TAG_W  = 4;
    localparam int LEN_W  = 11;
    localparam int WORD_W = 32;
    localparam int WIN_W  = 16;
    localparam int HDR_W  = 16;
    localparam int IDX_W  = 2;

    // Default largest frame; also sets the transmit limit
    localparam int MAX_FRAME_DEF = 1600;
    localparam int GRE_HDR       = 16;
    localparam int TX_HDR        = 24;

    // Queue between front end and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // GRE header words
    localparam logic [HDR_W-1:0] FLAG_MASK = 16'hEF7F;
    localparam logic [HDR_W-1:0] FLAG_WANT = 16'h2001;
    localparam logic [HDR_W-1:0] PROTO_PPP = 16'h880B;
    localparam logic [HDR_W-1:0] FLAG_SEQ  = 16'h1000;
    localparam logic [HDR_W-1:0] FLAG_ACK  = 16'h0080;

    localparam logic [WIN_W-1:0] ACK_WINDOW_RST = 16'd16;

    typedef enum logic [IDX_W-1:0] {
        CFG_LOCAL_ADDR  = 2'd0,
        CFG_REMOTE_ADDR = 2'd1,
        CFG_ACK_WINDOW  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_RX = 1'b0,
        OP_TX = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_DELIVER      = 4'd0,
        ST_DELIVER_HELD = 4'd1,
        ST_HELD         = 4'd2,
        ST_OLD          = 4'd3,
        ST_SHORT        = 4'd4,
        ST_FLAGS        = 4'd5,
        ST_LENGTH       = 4'd6,
        ST_NOSEQ        = 4'd7,
        ST_OVERSIZE     = 4'd8,
        ST_ADDRESS      = 4'd9,
        ST_PROTOCOL     = 4'd10,
        ST_HALTED       = 4'd11,
        ST_TX           = 4'd12
    } status_t;

    // Classified word from the front end. pre is the stateless verdict;
    // ST_DELIVER means the header passed and sequencing decides.
    typedef struct packed {
        status_t             pre;
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    len;
        logic                has_ack;
        logic                has_seq;
        logic [WORD_W-1:0]   seq;
        logic [WORD_W-1:0]   seq_m1;
        logic [WORD_W-1:0]   ack_word;
    } grs_item_t;

    // One result word, without the sequence snapshot
    typedef struct packed {
        status_t             status;
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    len;
        logic                last;
        logic                due;
    } grs_result_t;

    // Sequence counters reported with every result
    typedef struct packed {
        logic [WORD_W-1:0]   rx_seq;
        logic [WORD_W-1:0]   tx_seq;
        logic [WORD_W-1:0]   peer_ack;
    } grs_snap_t;

endpackage

FILE: rtl/grs_front.sv
// Front end: classifies one header word against size, address, protocol,
// flag and length rules. Pure logic. Depends on grs_pkg.
module grs_front #(
    parameter int MAX_FRAME = grs_pkg::MAX_FRAME_DEF
) (
    input  logic                        opcode,
    input  logic [grs_pkg::TAG_W-1:0]   packet_tag,
    input  logic [grs_pkg::LEN_W-1:0]   frame_len,
    input  logic [grs_pkg::WORD_W-1:0]  src_addr,
    input  logic [grs_pkg::WORD_W-1:0]  dst_addr,
    input  logic [grs_pkg::HDR_W-1:0]   gre_flags,
    input  logic [grs_pkg::HDR_W-1:0]   gre_protocol,
    input  logic [grs_pkg::LEN_W-1:0]   payload_len,
    input  logic [grs_pkg::WORD_W-1:0]  word_a,
    input  logic [grs_pkg::WORD_W-1:0]  word_b,
    input  logic [grs_pkg::WORD_W-1:0]  local_addr,
    input  logic [grs_pkg::WORD_W-1:0]  remote_addr,
    output grs_pkg::grs_item_t          item
);
    import grs_pkg::*;

    localparam logic [LEN_W-1:0] RX_LIMIT = LEN_W'(MAX_FRAME);
    localparam logic [LEN_W-1:0] TX_LIMIT = LEN_W'(MAX_FRAME - TX_HDR);
    localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(GRE_HDR);

    logic [LEN_W-1:0] room;

    assign room = frame_len - HDR_LEN;

    // Stateless verdict, first failing check wins
    always_comb
    begin
        item.tag      = packet_tag;
        item.has_ack  = (gre_flags & FLAG_ACK) != '0;
        item.has_seq  = (gre_flags & FLAG_SEQ) != '0;
        item.seq      = word_a;
        item.seq_m1   = word_a - WORD_W'(1);
        item.ack_word = item.has_seq ? word_b : word_a;
        if (opcode == OP_TX)
        begin
            item.len = frame_len;
            item.pre = (frame_len >= TX_LIMIT) ? ST_OVERSIZE : ST_TX;
        end
        else
        begin
            item.len = payload_len;
            if (frame_len >= RX_LIMIT)
                item.pre = ST_OVERSIZE;
            else if (frame_len < HDR_LEN)
                item.pre = ST_SHORT;
            else if (src_addr != remote_addr || dst_addr != local_addr)
                item.pre = ST_ADDRESS;
            else if (gre_protocol != PROTO_PPP)
                item.pre = ST_PROTOCOL;
            else if ((gre_flags & FLAG_MASK) != FLAG_WANT)
                item.pre = ST_FLAGS;
            else if (payload_len > room)
                item.pre = ST_LENGTH;
            else
                item.pre = ST_DELIVER;
        end
    end

endmodule

FILE: rtl/grs_queue.sv
// Short queue of classified words between front end and back end.
// Depends on grs_pkg.
module grs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  grs_pkg::grs_item_t  wr_item,
    output logic                full,
    output logic                rd_valid,
    output grs_pkg::grs_item_t  rd_item,
    input  logic                pop
);
    import grs_pkg::*;

    grs_item_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;

    assign push     = wr_en && !full;
    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_item  = entries_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

FILE: rtl/grs_back.sv
// Back end: sequence state, hold slot, ack pacing and the output register
// with its second-result slot. Depends on grs_pkg.
module grs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  grs_pkg::grs_item_t          q_item,
    output logic                        pop,
    input  logic [grs_pkg::WIN_W-1:0]   ack_window,
    output logic                        out_valid,
    input  logic                        out_stall,
    output grs_pkg::grs_result_t        out_res,
    output grs_pkg::grs_snap_t          out_snap
);
    import grs_pkg::*;

    // Sequence state
    logic [WORD_W-1:0]  rx_seq_reg, rx_seq_next;
    logic [WORD_W-1:0]  acked_reg, acked_next;
    logic [WORD_W-1:0]  tx_seq_reg, tx_seq_next;
    logic [WORD_W-1:0]  peer_ack_reg, peer_ack_next;
    logic [WORD_W-1:0]  held_seq_reg, held_seq_next;
    logic [LEN_W-1:0]   held_len_reg, held_len_next;
    logic [TAG_W-1:0]   held_tag_reg, held_tag_next;
    logic               halted_reg, halted_next;

    // Output register and the pending second result
    logic               out_valid_reg, out_valid_next;
    grs_result_t        out_res_reg, out_res_next;
    grs_snap_t          out_snap_reg, out_snap_next;
    logic               pend_valid_reg, pend_valid_next;
    grs_result_t        pend_res_reg, pend_res_next;

    logic               load;
    logic               proc;
    logic [WORD_W-1:0]  seq_gap;
    logic [WORD_W-1:0]  unacked;
    logic               due;
    logic               release_held;

    assign load = !out_valid_reg || !out_stall;
    assign proc = load && !pend_valid_reg && q_valid;
    assign pop  = proc;

    // Two independent distances off the incoming sequence word
    assign seq_gap = q_item.seq - rx_seq_reg;
    assign unacked = q_item.seq - acked_reg;
    assign due     = !unacked[WORD_W-1]
                     && unacked > WORD_W'(ack_window >> 1);
    assign release_held = seq_gap != WORD_W'(1) && held_len_reg != '0
                          && held_seq_reg == q_item.seq_m1;

    // Sequencing decision
    always_comb
    begin
        rx_seq_next     = rx_seq_reg;
        acked_next      = acked_reg;
        tx_seq_next     = tx_seq_reg;
        peer_ack_next   = peer_ack_reg;
        held_seq_next   = held_seq_reg;
        held_len_next   = held_len_reg;
        held_tag_next   = held_tag_reg;
        halted_next     = halted_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_snap_next   = out_snap_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;

        if (load)
        begin
            out_valid_next = pend_valid_reg || q_valid;
            out_res_next.status = q_item.pre;
            out_res_next.tag    = q_item.tag;
            out_res_next.len    = '0;
            out_res_next.last   = 1'b1;
            out_res_next.due    = 1'b0;

            if (pend_valid_reg)
            begin
                out_res_next    = pend_res_reg;
                pend_valid_next = 1'b0;
            end
            else if (q_valid)
            begin
                if (halted_reg)
                    out_res_next.status = ST_HALTED;
                else
                begin
                    case (q_item.pre)
                        ST_OVERSIZE, ST_ADDRESS, ST_PROTOCOL:
                            halted_next = 1'b1;
                        ST_TX:
                        begin
                            tx_seq_next      = tx_seq_reg + WORD_W'(1);
                            acked_next       = rx_seq_reg;
                            out_res_next.len = q_item.len;
                        end
                        ST_DELIVER:
                        begin
                            if (q_item.has_ack)
                                peer_ack_next = q_item.ack_word;
                            if (!q_item.has_seq)
                                out_res_next.status = ST_NOSEQ;
                            else if (seq_gap == '0 || seq_gap[WORD_W-1])
                                out_res_next.status = ST_OLD;
                            else if (seq_gap == WORD_W'(2))
                            begin
                                held_seq_next       = q_item.seq;
                                held_len_next       = q_item.len;
                                held_tag_next       = q_item.tag;
                                out_res_next.status = ST_HELD;
                            end
                            else
                            begin
                                rx_seq_next = q_item.seq;
                                if (due)
                                    acked_next = q_item.seq;
                                pend_res_next.status = ST_DELIVER;
                                pend_res_next.tag    = q_item.tag;
                                pend_res_next.len    = q_item.len;
                                pend_res_next.last   = 1'b1;
                                pend_res_next.due    = due;
                                if (release_held)
                                begin
                                    // held packet goes first, new one follows
                                    held_len_next        = '0;
                                    out_res_next.status  = ST_DELIVER_HELD;
                                    out_res_next.tag     = held_tag_reg;
                                    out_res_next.len     = held_len_reg;
                                    out_res_next.last    = 1'b0;
                                    pend_valid_next      = 1'b1;
                                end
                                else
                                    out_res_next = pend_res_next;
                            end
                        end
                        default:
                            ;
                    endcase
                end
            end
            out_snap_next.rx_seq   = rx_seq_next;
            out_snap_next.tx_seq   = tx_seq_next;
            out_snap_next.peer_ack = peer_ack_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_seq_reg     <= '0;
            acked_reg      <= '0;
            tx_seq_reg     <= '0;
            peer_ack_reg   <= '0;
            held_seq_reg   <= '0;
            held_len_reg   <= '0;
            held_tag_reg   <= '0;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            rx_seq_reg     <= rx_seq_next;
            acked_reg      <= acked_next;
            tx_seq_reg     <= tx_seq_next;
            peer_ack_reg   <= peer_ack_next;
            held_seq_reg   <= held_seq_next;
            held_len_reg   <= held_len_next;
            held_tag_reg   <= held_tag_next;
            halted_reg     <= halted_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        out_snap_reg <= out_snap_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_snap  = out_snap_reg;

endmodule

FILE: rtl/gre_rx_sequencer.sv
// Enhanced-GRE receive sequencer, top level.
// Path: an accepted word is classified, queued, then sequenced into the output register.
// Throughput: one word per cycle while out_stall is low; a word that releases a held
// packet yields two results, from the single output register and its second-result slot.
// Reset clears all sequence state and the hold slot, ack_window returns to 16,
// addresses to zero; the block accepts words right after reset.
module gre_rx_sequencer #(
    parameter int MAX_FRAME = grs_pkg::MAX_FRAME_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input words
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [grs_pkg::TAG_W-1:0]   packet_tag,
    input  logic [grs_pkg::LEN_W-1:0]   frame_len,
    input  logic [grs_pkg::WORD_W-1:0]  src_addr,
    input  logic [grs_pkg::WORD_W-1:0]  dst_addr,
    input  logic [grs_pkg::HDR_W-1:0]   gre_flags,
    input  logic [grs_pkg::HDR_W-1:0]   gre_protocol,
    input  logic [grs_pkg::LEN_W-1:0]   payload_len,
    input  logic [grs_pkg::WORD_W-1:0]  word_a,
    input  logic [grs_pkg::WORD_W-1:0]  word_b,
    // result words
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [3:0]                  status,
    output logic [grs_pkg::TAG_W-1:0]   out_tag,
    output logic [grs_pkg::LEN_W-1:0]   out_len,
    output logic                        last,
    output logic                        ack_due,
    output logic [grs_pkg::WORD_W-1:0]  ack_number,
    output logic [grs_pkg::WORD_W-1:0]  tx_sequence,
    output logic [grs_pkg::WORD_W-1:0]  peer_acked,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [grs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [grs_pkg::WORD_W-1:0]  cfg_data
);
    import grs_pkg::*;

    logic [WORD_W-1:0]  local_addr_reg;
    logic [WORD_W-1:0]  remote_addr_reg;
    logic [WIN_W-1:0]   ack_window_reg;

    grs_item_t          front_item;
    grs_item_t          q_item;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    grs_result_t        res;
    grs_snap_t          snap;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg  <= '0;
            remote_addr_reg <= '0;
            ack_window_reg  <= ACK_WINDOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_LOCAL_ADDR:  local_addr_reg  <= cfg_data;
                CFG_REMOTE_ADDR: remote_addr_reg <= cfg_data;
                CFG_ACK_WINDOW:  ack_window_reg  <= cfg_data[WIN_W-1:0];
                default:         ;
            endcase
        end
    end

    grs_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .opcode       (opcode),
        .packet_tag   (packet_tag),
        .frame_len    (frame_len),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .gre_flags    (gre_flags),
        .gre_protocol (gre_protocol),
        .payload_len  (payload_len),
        .word_a       (word_a),
        .word_b       (word_b),
        .local_addr   (local_addr_reg),
        .remote_addr  (remote_addr_reg),
        .item         (front_item)
    );

    assign in_stall = q_full;

    grs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_valid),
        .wr_item  (front_item),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .pop      (q_pop)
    );

    grs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (q_pop),
        .ack_window (ack_window_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (res),
        .out_snap   (snap)
    );

    assign status      = res.status;
    assign out_tag     = res.tag;
    assign out_len     = res.len;
    assign last        = res.last;
    assign ack_due     = res.due;
    assign ack_number  = snap.rx_seq;
    assign tx_sequence = snap.tx_seq;
    assign peer_acked  = snap.peer_ack;

    // Only a released held packet is a non-final result
    a_last_only_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last || status == ST_DELIVER_HELD))
        else $error("non-final result with wrong status");

    // A released held packet is followed at once by its successor's delivery
    a_held_then_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status == ST_DELIVER_HELD)
        |=> (out_valid && status == ST_DELIVER && last))
        else $error("released held packet not followed by delivery");

    // Standalone ack is only flagged on a delivery
    a_due_on_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ack_due) |-> (status == ST_DELIVER && last))
        else $error("ack_due on a non-delivery result");

    // Once halted, the block stays halted
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status == ST_HALTED)
        |=> (!out_valid || status == ST_HALTED))
        else $error("result after halt is not halted");

endmodule

FILE: tb/sv/gre_rx_sequencer_test.sv
// Self-checking testbench for gre_rx_sequencer: header words in, sequencing results out.
// Depends on grs_pkg and the gre_rx_sequencer RTL; keeps its own tracker of the
// sequence state and checks every result word, field by field, in order.
`timescale 1ns / 1ps

module gre_rx_sequencer_test;

    import grs_pkg::*;

    localparam int MAX_FRAME    = MAX_FRAME_DEF;
    localparam int LIMIT_CYCLES = 600000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 400;
    // index 3 decodes to no register
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

    // one header word as offered on the input channel
    typedef struct packed {
        opcode_t             op;
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    frame_len;
        logic [WORD_W-1:0]   src;
        logic [WORD_W-1:0]   dst;
        logic [HDR_W-1:0]    flags;
        logic [HDR_W-1:0]    proto;
        logic [LEN_W-1:0]    plen;
        logic [WORD_W-1:0]   word_a;
        logic [WORD_W-1:0]   word_b;
    } hdr_word_t;

    // one result word with its counter snapshot
    typedef struct packed {
        status_t             status;
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    len;
        logic                last;
        logic                due;
        logic [WORD_W-1:0]   ack_number;
        logic [WORD_W-1:0]   tx_sequence;
        logic [WORD_W-1:0]   peer_acked;
    } seq_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                opcode = 1'b0;
    logic [TAG_W-1:0]    packet_tag = '0;
    logic [LEN_W-1:0]    frame_len = '0;
    logic [WORD_W-1:0]   src_addr = '0;
    logic [WORD_W-1:0]   dst_addr = '0;
    logic [HDR_W-1:0]    gre_flags = '0;
    logic [HDR_W-1:0]    gre_protocol = '0;
    logic [LEN_W-1:0]    payload_len = '0;
    logic [WORD_W-1:0]   word_a = '0;
    logic [WORD_W-1:0]   word_b = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [3:0]          status;
    logic [TAG_W-1:0]    out_tag;
    logic [LEN_W-1:0]    out_len;
    logic                last;
    logic                ack_due;
    logic [WORD_W-1:0]   ack_number;
    logic [WORD_W-1:0]   tx_sequence;
    logic [WORD_W-1:0]   peer_acked;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [WORD_W-1:0]   cfg_data = '0;

    gre_rx_sequencer dut (.*);

    always #10 clk = ~clk;

    // register shadows
    logic [WORD_W-1:0]   addr_local = '0;
    logic [WORD_W-1:0]   addr_remote = '0;
    logic [WIN_W-1:0]    win_size = ACK_WINDOW_RST;

    // sequence state tracker
    logic [WORD_W-1:0]   seq_rx = '0;
    logic [WORD_W-1:0]   seq_acked = '0;
    logic [WORD_W-1:0]   seq_tx = '0;
    logic [WORD_W-1:0]   ack_from_peer = '0;
    logic [WORD_W-1:0]   park_seq = '0;
    logic [LEN_W-1:0]    park_len = '0;
    logic [TAG_W-1:0]    park_tag = '0;
    logic                is_halted = 1'b0;

    hdr_word_t           header_q[$];
    seq_result_t         pending_results[$];
    hdr_word_t           cur_hdr;
    seq_result_t         want_res;

    // generator's copy of the receive sequence, exact for well-formed words
    logic [WORD_W-1:0]   gen_rx = '0;

    int                  err_count = 0;
    int                  results_seen = 0;
    int                  cycle_count = 0;
    bit                  quiet_tail = 1'b0;
    int                  gap_left = 0;
    int                  run_left = 0;
    int                  stall_left = 0;
    int                  free_left = 0;
    int                  hold_left = 0;
    bit                  hold_done = 1'b0;

    //------------------------------------------------------------------
    // Sequence tracker
    //------------------------------------------------------------------
    task automatic note_result(input status_t st, input logic [TAG_W-1:0] tag,
                               input logic [LEN_W-1:0] len, input logic lst,
                               input logic due);
        seq_result_t r;
        r.status      = st;
        r.tag         = tag;
        r.len         = len;
        r.last        = lst;
        r.due         = due;
        r.ack_number  = seq_rx;
        r.tx_sequence = seq_tx;
        r.peer_acked  = ack_from_peer;
        pending_results.push_back(r);
    endtask

    task automatic track_sequence(input hdr_word_t h);
        logic [WORD_W-1:0] seq_gap;
        logic [WORD_W-1:0] unacked;
        logic              due;
        if (is_halted)
            note_result(ST_HALTED, h.tag, '0, 1'b1, 1'b0);
        else if (h.op == OP_TX)
        begin
            if (h.frame_len >= MAX_FRAME - TX_HDR)
            begin
                is_halted = 1'b1;
                note_result(ST_OVERSIZE, h.tag, '0, 1'b1, 1'b0);
            end
            else
            begin
                seq_tx    = seq_tx + 32'd1;
                seq_acked = seq_rx;
                note_result(ST_TX, h.tag, h.frame_len, 1'b1, 1'b0);
            end
        end
        else if (h.frame_len >= MAX_FRAME)
        begin
            is_halted = 1'b1;
            note_result(ST_OVERSIZE, h.tag, '0, 1'b1, 1'b0);
        end
        else if (h.frame_len < GRE_HDR)
            note_result(ST_SHORT, h.tag, '0, 1'b1, 1'b0);
        else if (h.src != addr_remote || h.dst != addr_local)
        begin
            is_halted = 1'b1;
            note_result(ST_ADDRESS, h.tag, '0, 1'b1, 1'b0);
        end
        else if (h.proto != PROTO_PPP)
        begin
            is_halted = 1'b1;
            note_result(ST_PROTOCOL, h.tag, '0, 1'b1, 1'b0);
        end
        else if ((h.flags & FLAG_MASK) != FLAG_WANT)
            note_result(ST_FLAGS, h.tag, '0, 1'b1, 1'b0);
        else if (int'(h.plen) > int'(h.frame_len) - GRE_HDR)
            note_result(ST_LENGTH, h.tag, '0, 1'b1, 1'b0);
        else
        begin
            // ack word sits behind the sequence word when both are present
            if ((h.flags & FLAG_ACK) != '0)
                ack_from_peer = ((h.flags & FLAG_SEQ) != '0) ? h.word_b : h.word_a;
            seq_gap = h.word_a - seq_rx;
            if ((h.flags & FLAG_SEQ) == '0)
                note_result(ST_NOSEQ, h.tag, '0, 1'b1, 1'b0);
            else if (seq_gap == '0 || seq_gap[31])
                note_result(ST_OLD, h.tag, '0, 1'b1, 1'b0);
            else if (seq_gap == 32'd2)
            begin
                park_seq = h.word_a;
                park_len = h.plen;
                park_tag = h.tag;
                note_result(ST_HELD, h.tag, '0, 1'b1, 1'b0);
            end
            else
            begin
                seq_rx = h.word_a;
                // parked packet directly in front of this one goes out first
                if (seq_gap > 32'd1 && park_len != '0 && park_seq == h.word_a - 32'd1)
                begin
                    note_result(ST_DELIVER_HELD, park_tag, park_len, 1'b0, 1'b0);
                    park_len = '0;
                end
                unacked = seq_rx - seq_acked;
                due = !unacked[31] && (unacked > (win_size >> 1));
                if (due)
                    seq_acked = seq_rx;
                note_result(ST_DELIVER, h.tag, h.plen, 1'b1, due);
            end
        end
    endtask

    //------------------------------------------------------------------
    // Header word builders
    //------------------------------------------------------------------
    function automatic hdr_word_t noise_hdr();
        hdr_word_t h;
        h.op        = $urandom_range(0, 1) ? OP_TX : OP_RX;
        h.tag       = TAG_W'($urandom);
        h.frame_len = LEN_W'($urandom);
        h.src       = $urandom;
        h.dst       = $urandom;
        h.flags     = HDR_W'($urandom);
        h.proto     = HDR_W'($urandom);
        h.plen      = LEN_W'($urandom);
        h.word_a    = $urandom;
        h.word_b    = $urandom;
        return h;
    endfunction

    function automatic hdr_word_t good_rx(input logic [HDR_W-1:0] flags,
                                          input logic [WORD_W-1:0] wa, input int plen,
                                          input int flen);
        hdr_word_t h;
        h           = noise_hdr();
        h.op        = OP_RX;
        h.frame_len = LEN_W'(flen);
        h.src       = addr_remote;
        h.dst       = addr_local;
        h.flags     = flags;
        h.proto     = PROTO_PPP;
        h.plen      = LEN_W'(plen);
        h.word_a    = wa;
        return h;
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 64)
                                          : $urandom_range(0, MAX_FRAME - 1 - GRE_HDR);
    endfunction

    function automatic int fit_len(input int plen);
        return plen + GRE_HDR + $urandom_range(0, MAX_FRAME - 1 - GRE_HDR - plen);
    endfunction

    // sequenced word at an offset from the current receive sequence
    task automatic send_seq(input logic [WORD_W-1:0] offset, input int plen, input int flen);
        logic [HDR_W-1:0]  fl;
        logic [WORD_W-1:0] wa;
        wa = gen_rx + offset;
        fl = FLAG_WANT | FLAG_SEQ | ($urandom_range(0, 1) ? FLAG_ACK : 16'h0000);
        header_q.push_back(good_rx(fl, wa, plen, flen));
        if (offset != '0 && !offset[31] && offset != 32'd2)
            gen_rx = wa;
    endtask

    task automatic send_any(input logic [WORD_W-1:0] offset);
        int plen;
        plen = pick_len();
        send_seq(offset, plen, fit_len(plen));
    endtask

    task automatic send_noseq(input logic [HDR_W-1:0] flags, input logic [WORD_W-1:0] wa);
        int plen;
        plen = pick_len();
        header_q.push_back(good_rx(flags, wa, plen, fit_len(plen)));
    endtask

    task automatic send_tx(input int flen);
        hdr_word_t h;
        h           = noise_hdr();
        h.op        = OP_TX;
        h.frame_len = LEN_W'(flen);
        header_q.push_back(h);
    endtask

    task automatic send_short(input int flen);
        hdr_word_t h;
        h           = noise_hdr();
        h.op        = OP_RX;
        h.frame_len = LEN_W'(flen);
        header_q.push_back(h);
    endtask

    task automatic send_bad_len(input int flen, input int plen);
        header_q.push_back(good_rx(FLAG_WANT | FLAG_SEQ, gen_rx + 32'd1, plen, flen));
    endtask

    task automatic send_bad_flags(input logic [HDR_W-1:0] flags);
        header_q.push_back(good_rx(flags, gen_rx + 32'd1, 4, 40));
    endtask

    // mostly well-formed traffic, with noise and broken words mixed in
    task automatic random_items(input int n);
        int               pick;
        int               fl_len;
        logic [HDR_W-1:0] fl;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_any(32'd1);
            else if (pick < 40)
                send_any($urandom_range(3, 6));
            else if (pick < 50)
            begin
                send_any(32'd2);
                if ($urandom_range(0, 4) != 0)
                    send_any(32'd3);
                else
                    send_any(32'd1);
            end
            else if (pick < 56)
                send_any(-$urandom_range(0, 5));
            else if (pick < 58)
                send_any(32'h8000_0000 | $urandom);
            else if (pick < 61)
                send_any($urandom_range(3, 32'h7FFF_FFFF));
            else if (pick < 72)
                send_tx($urandom_range(0, MAX_FRAME - TX_HDR - 1));
            else if (pick < 78)
                send_noseq(FLAG_WANT | ($urandom_range(0, 1) ? FLAG_ACK : 16'h0000), $urandom);
            else if (pick < 84)
            begin
                do
                    fl = HDR_W'($urandom);
                while ((fl & FLAG_MASK) == FLAG_WANT);
                send_bad_flags(fl);
            end
            else if (pick < 89)
            begin
                fl_len = $urandom_range(GRE_HDR, MAX_FRAME - 1);
                send_bad_len(fl_len, $urandom_range(fl_len - GRE_HDR + 1, 2047));
            end
            else
                send_short($urandom_range(0, GRE_HDR - 1));
        end
    endtask

    //------------------------------------------------------------------
    // Configuration writes and phase control
    //------------------------------------------------------------------
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LOCAL_ADDR:  addr_local  = val;
            CFG_REMOTE_ADDR: addr_remote = val;
            CFG_ACK_WINDOW:  win_size    = val[WIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (header_q.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    //------------------------------------------------------------------
    // Input driver: one header word per handshake
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                track_sequence(cur_hdr);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (header_q.size() != 0)
                begin
                    cur_hdr = header_q.pop_front();
                    opcode       <= cur_hdr.op;
                    packet_tag   <= cur_hdr.tag;
                    frame_len    <= cur_hdr.frame_len;
                    src_addr     <= cur_hdr.src;
                    dst_addr     <= cur_hdr.dst;
                    gre_flags    <= cur_hdr.flags;
                    gre_protocol <= cur_hdr.proto;
                    payload_len  <= cur_hdr.plen;
                    word_a       <= cur_hdr.word_a;
                    word_b       <= cur_hdr.word_b;
                    in_valid     <= 1'b1;
                    // idle burst after a random run of back-to-back words
                    if (!quiet_tail)
                    begin
                        if (run_left > 0)
                            run_left--;
                        else
                        begin
                            gap_left = $urandom_range(1, 18);
                            run_left = $urandom_range(0, 40);
                        end
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Output stall: random bursts, plus one long hold-off to back up the block
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (quiet_tail)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            stall_left = $urandom_range(1, 18) - 1;
            free_left  = $urandom_range(0, 60);
            out_stall <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // Result monitor
    //------------------------------------------------------------------
    function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result word: expected none, actual status %0d tag %0d",
                         $time, status, out_tag);
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("status", want_res.status, status);
                check_field("out_tag", want_res.tag, out_tag);
                check_field("out_len", want_res.len, out_len);
                check_field("last", want_res.last, last);
                check_field("ack_due", want_res.due, ack_due);
                check_field("ack_number", want_res.ack_number, ack_number);
                check_field("tx_sequence", want_res.tx_sequence, tx_sequence);
                check_field("peer_acked", want_res.peer_acked, peer_acked);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial
    begin
        logic [WORD_W-1:0] a_loc;
        logic [WORD_W-1:0] a_rem;
        logic [WORD_W-1:0] win;
        hdr_word_t         h;
        int                kind;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_LOCAL_ADDR, $urandom);
        write_reg(CFG_REMOTE_ADDR, $urandom);

        // directed: extremes, hold and release, each non-fatal drop reason
        send_tx(0);
        send_tx(MAX_FRAME - TX_HDR - 1);
        send_seq(32'd1, 0, GRE_HDR);                 // smallest frame
        send_seq(32'd0, 7, 40);                      // duplicate
        send_seq(32'd2, 5, 60);                      // two ahead: held
        send_seq(32'd3, 9, 60);                      // releases the held word first
        send_seq(32'd2, 0, 30);                      // held with zero length
        send_seq(32'd3, 4, 30);                      // zero-length hold stays put
        send_seq(32'd2, 11, 50);
        send_seq(32'd1, 3, 50);                      // next in order, no release
        send_seq(32'd2, 12, 50);                     // overwrites the hold
        send_seq(32'd3, 13, 50);                     // releases the overwriting word
        send_noseq(FLAG_WANT | FLAG_ACK, 32'hFFFF_FFFF);
        send_noseq(FLAG_WANT, $urandom);
        send_bad_flags(16'hFFFF);
        send_bad_len(100, 85);
        send_seq(32'd1, 84, 100);                    // payload exactly fills the frame
        send_short(GRE_HDR - 1);
        send_short(0);
        send_seq(32'd1, MAX_FRAME - 1 - GRE_HDR, MAX_FRAME - 1);
        send_bad_len(GRE_HDR, 2047);
        send_seq(32'h7FFF_FFFF, 1, 20);              // farthest still ahead
        send_seq(32'h8000_0000, 1, 20);              // half-way round counts as old
        send_tx(17);
        wait_drained();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            a_loc = $urandom;
            a_rem = $urandom;
            case (ph)
                0: win = 1;
                1: begin a_loc = '0; a_rem = '0; win = 16'hFFFF; end
                2: begin a_loc = '1; a_rem = '1; win = 0; end
                3: win = $urandom_range(1, 16'hFFFF);
                4: win = 2;
                default: win = ACK_WINDOW_RST;
            endcase
            write_reg(CFG_LOCAL_ADDR, a_loc);
            write_reg(CFG_REMOTE_ADDR, a_rem);
            write_reg(CFG_ACK_WINDOW, win);
            if (ph == 0)
                write_reg(CFG_SPARE, $urandom);
            if (ph == 5)
                quiet_tail = 1'b1;
            random_items(230);
            wait_drained();
        end

        // one fatal word, then the halted block sees raw noise
        kind = $urandom_range(0, 3);
        case (kind)
            0: begin
                h = noise_hdr();
                h.op = OP_RX;
                h.frame_len = LEN_W'($urandom_range(MAX_FRAME, 2047));
            end
            1: begin
                h = noise_hdr();
                h.op = OP_TX;
                h.frame_len = LEN_W'($urandom_range(MAX_FRAME - TX_HDR, 2047));
            end
            2: begin
                h = good_rx(FLAG_WANT | FLAG_SEQ, gen_rx + 32'd1, 4, 40);
                if ($urandom_range(0, 1))
                    h.src = addr_remote ^ (32'd1 << $urandom_range(0, 31));
                else
                    h.dst = addr_local ^ (32'd1 << $urandom_range(0, 31));
            end
            default: begin
                h = good_rx(FLAG_WANT | FLAG_SEQ, gen_rx + 32'd1, 4, 40);
                h.proto = PROTO_PPP ^ 16'($urandom_range(1, 16'hFFFF));
            end
        endcase
        header_q.push_back(h);
        for (int i = 0; i < 40; i++)
            header_q.push_back(noise_hdr());
        wait_drained();

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/grs_pkg.sv
rtl/grs_front.sv
rtl/grs_queue.sv
rtl/grs_back.sv
rtl/gre_rx_sequencer.sv
tb/sv/gre_rx_sequencer_test.sv
